// ----- rtl/prf_pkg.sv -----
// Shared constants and types of the page replacement block.
package prf_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 16;
	localparam int STAMP_W   = 32;
	localparam int CNT_W     = 32;
	localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int COUNT_W   = $clog2(FRAMES + 1);
	localparam int NCFG_W    = 4;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 1;
	localparam int ENTRY_W   = PAGE_BITS + STAMP_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'b1;

	// policy codes
	localparam logic POL_FIFO = 1'b0;
	localparam logic POL_LRU  = 1'b1;

	// action codes
	localparam logic ACT_REF   = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef struct packed {
		logic               policy;
		logic [COUNT_W-1:0] n_act;
	} cfg_t;

	typedef struct packed {
		logic               we;
		logic [FRAME_W-1:0] waddr;
		logic [ENTRY_W-1:0] wdata;
		logic               re;
		logic [FRAME_W-1:0] raddr;
	} ram_req_t;

endpackage

// ----- rtl/prf_in_if.sv -----
// Input channel: one page reference or clear word.
interface prf_in_if;
	import prf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [PAGE_BITS-1:0] page_number;

	modport source (output valid, action, page_number, input ready);
	modport sink (input valid, action, page_number, output ready);
endinterface

// ----- rtl/prf_out_if.sv -----
// Output channel: one lookup result word.
interface prf_out_if;
	import prf_pkg::*;

	logic               valid;
	logic               ready;
	logic               hit;
	logic [FRAME_W-1:0] frame_index;
	logic [CNT_W-1:0]   hit_count;
	logic [CNT_W-1:0]   fault_count;

	modport source (output valid, hit, frame_index, hit_count, fault_count, input ready);
	modport sink (input valid, hit, frame_index, hit_count, fault_count, output ready);
endinterface

// ----- rtl/prf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module prf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/prf_ctrl.sv -----
// Lookup sequencer: frame scan, victim choice, write-back and result register.
module prf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prf_pkg::cfg_t                 cfg,
	prf_in_if.sink                        pages,
	prf_out_if.source                     results,
	output prf_pkg::ram_req_t             ram_req,
	input  logic [prf_pkg::ENTRY_W-1:0]   ram_rdata
);
	import prf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]           state_q;
	logic                 act_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [COUNT_W-1:0]   issue_q;
	logic                 cmp_v_s1;
	logic [FRAME_W-1:0]   cmp_idx_s1;
	logic                 found_q;
	logic [FRAME_W-1:0]   hit_idx_q;
	logic                 have_min_q;
	logic [FRAME_W-1:0]   min_idx_q;
	logic [STAMP_W-1:0]   min_stamp_q;
	logic [STAMP_W-1:0]   time_q;
	logic [FRAME_W-1:0]   ptr_q;
	logic [CNT_W-1:0]     hits_q;
	logic [CNT_W-1:0]     faults_q;
	logic [FRAMES-1:0]    valid_q;

	logic                 out_v_q;
	logic                 out_hit_q;
	logic [FRAME_W-1:0]   out_idx_q;
	logic [CNT_W-1:0]     out_hits_q;
	logic [CNT_W-1:0]     out_faults_q;

	logic                 accept;
	logic                 out_free;
	logic                 finish;
	logic                 issue_go;
	logic [PAGE_BITS-1:0] rd_page;
	logic [STAMP_W-1:0]   rd_stamp;
	logic                 empty_any;
	logic [FRAME_W-1:0]   empty_idx;
	logic [FRAME_W-1:0]   ptr_eff;
	logic [FRAME_W-1:0]   slot;
	logic [FRAME_W-1:0]   ptr_next;
	logic [CNT_W-1:0]     hits_next;
	logic [CNT_W-1:0]     faults_next;
	logic [STAMP_W-1:0]   time_next;

	assign accept   = pages.valid && pages.ready;
	assign out_free = !out_v_q || results.ready;
	assign finish   = (state_q == S_FIN) && out_free;
	assign issue_go = (state_q == S_SCAN) && (issue_q < cfg.n_act);

	assign pages.ready = (state_q == S_IDLE);

	assign rd_page  = ram_rdata[ENTRY_W-1:STAMP_W];
	assign rd_stamp = ram_rdata[STAMP_W-1:0];

	// find the lowest empty frame among those taking part
	always_comb begin
		empty_any = 1'b0;
		empty_idx = '0;
		for (int j = FRAMES - 1; j >= 0; j--) begin
			if ((COUNT_W'(j) < cfg.n_act) && !valid_q[j]) begin
				empty_any = 1'b1;
				empty_idx = FRAME_W'(j);
			end
		end
	end

	// pick the frame that hits or gets filled
	always_comb begin
		ptr_eff = (COUNT_W'(ptr_q) >= cfg.n_act) ? '0 : ptr_q;
		priority if (found_q) begin
			slot = hit_idx_q;
		end else if (cfg.policy == POL_FIFO) begin
			slot = ptr_eff;
		end else if (empty_any) begin
			slot = empty_idx;
		end else begin
			slot = min_idx_q;
		end
		ptr_next = ((COUNT_W'(slot) + COUNT_W'(1)) >= cfg.n_act) ? '0 : slot + FRAME_W'(1);
		hits_next   = (found_q && hits_q != '1) ? hits_q + CNT_W'(1) : hits_q;
		faults_next = (!found_q && faults_q != '1) ? faults_q + CNT_W'(1) : faults_q;
		time_next   = (time_q != '1) ? time_q + STAMP_W'(1) : time_q;
	end

	// drive the frame memory
	always_comb begin
		ram_req.re    = issue_go;
		ram_req.raddr = issue_q[FRAME_W-1:0];
		ram_req.we    = finish && (act_q == ACT_REF) &&
			(!found_q || cfg.policy == POL_LRU);
		ram_req.waddr = slot;
		ram_req.wdata = {page_q, time_q};
	end

	// sequence one word through scan and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			issue_q    <= '0;
			cmp_v_s1   <= 1'b0;
			found_q    <= 1'b0;
			have_min_q <= 1'b0;
			time_q     <= '0;
			ptr_q      <= '0;
			hits_q     <= '0;
			faults_q   <= '0;
			valid_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						issue_q    <= '0;
						cmp_v_s1   <= 1'b0;
						found_q    <= 1'b0;
						have_min_q <= 1'b0;
						state_q    <= (pages.action == ACT_CLEAR) ? S_FIN : S_SCAN;
					end
				end
				S_SCAN: begin
					cmp_v_s1 <= issue_go;
					if (issue_go) begin
						issue_q <= issue_q + COUNT_W'(1);
					end
					// compare the entry read last cycle
					if (cmp_v_s1) begin
						if (!found_q && valid_q[cmp_idx_s1] && rd_page == page_q) begin
							found_q <= 1'b1;
						end
						if (!have_min_q || rd_stamp < min_stamp_q) begin
							have_min_q <= 1'b1;
						end
					end
					if (!issue_go && !cmp_v_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (act_q == ACT_CLEAR) begin
							valid_q  <= '0;
							time_q   <= '0;
							ptr_q    <= '0;
							hits_q   <= '0;
							faults_q <= '0;
						end else begin
							hits_q   <= hits_next;
							faults_q <= faults_next;
							time_q   <= time_next;
							if (!found_q) begin
								valid_q[slot] <= 1'b1;
								if (cfg.policy == POL_FIFO) begin
									ptr_q <= ptr_next;
								end
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the word, the scan index and the best candidates
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= pages.action;
			page_q <= pages.page_number;
		end
		if (issue_go) begin
			cmp_idx_s1 <= issue_q[FRAME_W-1:0];
		end
		if (state_q == S_SCAN && cmp_v_s1) begin
			if (!found_q && valid_q[cmp_idx_s1] && rd_page == page_q) begin
				hit_idx_q <= cmp_idx_s1;
			end
			if (!have_min_q || rd_stamp < min_stamp_q) begin
				min_idx_q   <= cmp_idx_s1;
				min_stamp_q <= rd_stamp;
			end
		end
	end

	// result register: load on finish, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (finish) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (act_q == ACT_CLEAR) begin
				out_hit_q    <= 1'b0;
				out_idx_q    <= '0;
				out_hits_q   <= '0;
				out_faults_q <= '0;
			end else begin
				out_hit_q    <= found_q;
				out_idx_q    <= slot;
				out_hits_q   <= hits_next;
				out_faults_q <= faults_next;
			end
		end
	end

	assign results.valid       = out_v_q;
	assign results.hit         = out_hit_q;
	assign results.frame_index = out_idx_q;
	assign results.hit_count   = out_hits_q;
	assign results.fault_count = out_faults_q;
endmodule

// ----- rtl/page_replacement_fifo_lru.sv -----
// Page replacement block top level: configuration registers, frame memory, sequencer.
//
// The pages channel takes one word per lookup: a page reference or a clear.
// The results channel returns exactly one word per accepted input word: the
// hit flag, the frame that hit or was filled, and saturating hit and fault
// counts. Configuration is written through cfg_we, cfg_index and cfg_data:
// index 0 picks the policy (FIFO or LRU), index 1 the number of frames in use.
// Write configuration only while no word is in flight.
// A reference is accepted, scanned through the frame memory (n reads, one
// per cycle over its single read port, then a compare of the last read and a
// closing step) and written back; a clear skips the scan.
// One word is in work at a time; the next is accepted once the previous one
// has been written back, even if its result still waits in the output register.
// If the receiver stalls, the result is held and the following word stops in
// write-back until the output register is free.
// Reset empties all frames, zeroes the clock, pointer and counters, and sets
// the policy to FIFO with 8 frames in use; no memory sweep is needed.
module page_replacement_fifo_lru (
	input  logic                            clk,
	input  logic                            arst_n,
	prf_in_if.sink                          pages,
	prf_out_if.source                       results,
	input  logic                            cfg_we,
	input  logic [prf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [prf_pkg::CFG_W-1:0]       cfg_data
);
	import prf_pkg::*;

	logic               policy_q;
	logic [NCFG_W-1:0]  frames_q;
	cfg_t               cfg;
	ram_req_t           ram_req;
	logic [ENTRY_W-1:0] ram_rdata;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
			frames_q <= NCFG_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY: policy_q <= cfg_data[0];
				REG_FRAMES: frames_q <= cfg_data[NCFG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the frame count to one through FRAMES
	always_comb begin
		cfg.policy = policy_q;
		priority if (frames_q == '0) begin
			cfg.n_act = COUNT_W'(1);
		end else if (32'(frames_q) > FRAMES) begin
			cfg.n_act = COUNT_W'(FRAMES);
		end else begin
			cfg.n_act = COUNT_W'(frames_q);
		end
	end

	prf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pages     (pages),
		.results   (results),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	prf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (FRAMES)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);
endmodule

// ----- rtl/prf_checker.sv -----
// Port-level checker for the page replacement block, with its bind.
module prf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          out_hit,
	input logic [prf_pkg::FRAME_W-1:0]   out_frame_index,
	input logic [prf_pkg::CNT_W-1:0]     out_hit_count,
	input logic [prf_pkg::CNT_W-1:0]     out_fault_count
);
	import prf_pkg::*;

	// one word in work at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous word still in work");

	// a hit result always carries a nonzero hit count
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_hit |-> out_hit_count != '0)
		else $error("hit reported with zero hit count");

	// a fill of a nonzero frame is a fault and must be counted
	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_hit && out_frame_index != '0 |-> out_fault_count != '0)
		else $error("fault reported with zero fault count");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
			$stable(out_frame_index) && $stable(out_hit_count) &&
			$stable(out_fault_count))
		else $error("stalled result changed");
endmodule

bind page_replacement_fifo_lru prf_checker u_prf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (pages.valid),
	.in_ready        (pages.ready),
	.out_valid       (results.valid),
	.out_ready       (results.ready),
	.out_hit         (results.hit),
	.out_frame_index (results.frame_index),
	.out_hit_count   (results.hit_count),
	.out_fault_count (results.fault_count)
);
